// ===== hdl/bfbp_pkg.sv =====
// Shared types and field widths for the best-fit bin packer.
package bfbp_pkg;

  // Field widths of the item and result streams.
  localparam int ID_W   = 31;
  localparam int SIZE_W = 31;
  localparam int BIDX_W = 6;

  // Padded stream data widths (whole bytes).
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // Bit positions of the result flags in out_tuser.
  localparam int FLAG_OPENED   = 0;
  localparam int FLAG_OVERFLOW = 1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  // Control from the sequencer to the fit comparator.
  typedef struct packed {
    logic init;    // restart the search for a new item
    logic sample;  // a bin's remaining space is on the read port
  } cmp_ctrl_t;

endpackage

// ===== hdl/bfbp_bin_store.sv =====
// Remaining-space memory of the bins, one write and one registered read port.
module bfbp_bin_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bfbp_pkg::SIZE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [bfbp_pkg::SIZE_W-1:0] rd_data
);

  logic [bfbp_pkg::SIZE_W-1:0] mem [DEPTH];
  logic [bfbp_pkg::SIZE_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/bfbp_fit_cmp.sv =====
// Shared subtract-and-compare unit that tracks the tightest fitting bin.
module bfbp_fit_cmp #(
  parameter int IW = 6
) (
  input  logic                        clk,
  input  bfbp_pkg::cmp_ctrl_t         ctrl,
  input  logic [bfbp_pkg::SIZE_W-1:0] cap,
  input  logic [bfbp_pkg::SIZE_W-1:0] size,
  input  logic [bfbp_pkg::SIZE_W-1:0] rem,
  input  logic [IW-1:0]               rem_idx,
  output logic                        found,
  output logic [IW-1:0]               best_idx,
  output logic [bfbp_pkg::SIZE_W-1:0] best_rem
);

  logic [bfbp_pkg::SIZE_W:0]   best_slack_r, best_slack_nxt;
  logic [IW-1:0]               best_idx_r, best_idx_nxt;
  logic                        found_r, found_nxt;
  logic [bfbp_pkg::SIZE_W-1:0] diff;
  logic                        fits;

  // One bin per cycle: it is a candidate when the item fits and the slack
  // left behind is strictly below the best so far (lowest index wins ties).
  assign diff = rem - size;
  assign fits = (rem >= size) && ({1'b0, diff} < best_slack_r);

  always_comb begin
    best_slack_nxt = best_slack_r;
    best_idx_nxt   = best_idx_r;
    found_nxt      = found_r;
    if (ctrl.init) begin
      best_slack_nxt = {1'b0, cap} + 1'b1;
      best_idx_nxt   = '0;
      found_nxt      = 1'b0;
    end else if (ctrl.sample && fits) begin
      best_slack_nxt = {1'b0, diff};
      best_idx_nxt   = rem_idx;
      found_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    best_slack_r <= best_slack_nxt;
    best_idx_r   <= best_idx_nxt;
    found_r      <= found_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  // The winning slack is the bin's new remaining space.
  assign best_rem = best_slack_r[bfbp_pkg::SIZE_W-1:0];

endmodule

// ===== hdl/best_fit_bin_packer_top.sv =====
// Online best-fit bin packer: places each request in the open bin with the
// least slack left, opening a new bin when none fits and flagging an overflow
// when every bin is in use. An item is taken when the block is idle, then the
// open bins are read back one per cycle from the bin memory, which has one
// write and one read port, through one shared compare unit. The block is not
// ready again until it has scanned the open bins and posted the result, and the
// next request is taken once it is back in idle. A finished result waits in an
// output register, and the next request may be taken while it waits. The
// placement of that next request then waits until the previous result has left
// the output register. The capacity register is written only while idle, and a
// capacity write takes priority over a request in the same cycle. A start flag
// on a request empties all bins before that request is placed.
module best_fit_bin_packer_top #(
  parameter int MAX_BINS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Capacity register write.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfbp_pkg::SIZE_W-1:0]      cfg_data,
  // Item stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [30:0] item_id, [61:31] item_size, [63:62] zero
  input  logic [bfbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] start_set
  input  logic                             in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [30:0] placed_id, [36:31] bin_index, [39:37] zero
  output logic [bfbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] opened_new, [1] overflow
  output logic [bfbp_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int OW = $clog2(MAX_BINS + 1);
  localparam int ID_W = bfbp_pkg::ID_W;
  localparam int SZ_W = bfbp_pkg::SIZE_W;

  bfbp_pkg::state_t    state_r, state_nxt;
  logic [SZ_W-1:0]     cap_r;
  logic [OW-1:0]       open_r, open_nxt;
  logic [OW-1:0]       scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [ID_W-1:0]     id_r;
  logic [SZ_W-1:0]     size_r;
  logic                out_vld_r, out_vld_nxt;
  logic [bfbp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [bfbp_pkg::OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  logic                in_acc;
  logic [ID_W-1:0]     in_id;
  logic [SZ_W-1:0]     in_size;
  logic                out_free;
  logic                full;

  bfbp_pkg::cmp_ctrl_t cmp_ctrl;
  logic                found;
  logic [IW-1:0]       best_idx;
  logic [SZ_W-1:0]     best_rem;

  logic                rd_en;
  logic [SZ_W-1:0]     rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [SZ_W-1:0]     wr_data;
  logic [IW-1:0]       res_idx;
  logic [IW+bfbp_pkg::BIDX_W-1:0] res_idx_ext;

  assign in_id   = in_tdata[ID_W-1:0];
  assign in_size = in_tdata[ID_W+SZ_W-1:ID_W];

  assign cfg_ready = (state_r == bfbp_pkg::ST_IDLE);
  assign in_tready = (state_r == bfbp_pkg::ST_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign full      = (open_r == OW'(MAX_BINS));

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Item registers; the size is clamped to the capacity on entry.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r   <= in_id;
      size_r <= (in_size > cap_r) ? cap_r : in_size;
    end
  end

  // Sequencer: scan the open bins, then place the item and post the result.
  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    cmp_ctrl.init   = 1'b0;
    cmp_ctrl.sample = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = open_r[IW-1:0];
    wr_data       = cap_r - size_r;
    res_idx       = open_r[IW-1:0];

    unique case (state_r)
      bfbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmp_ctrl.init = 1'b1;
          scan_nxt      = '0;
          if (in_tuser) begin
            open_nxt = '0;
          end
          state_nxt = bfbp_pkg::ST_SCAN;
        end
      end
      bfbp_pkg::ST_SCAN: begin
        cmp_ctrl.sample = pend_r;
        if (scan_r != open_r) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[IW-1:0];
          scan_nxt     = scan_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = bfbp_pkg::ST_DECIDE;
        end
      end
      bfbp_pkg::ST_DECIDE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_user_nxt = '0;
          if (found) begin
            wr_en   = 1'b1;
            wr_addr = best_idx;
            wr_data = best_rem;
            res_idx = best_idx;
          end else if (!full) begin
            wr_en    = 1'b1;
            open_nxt = open_r + 1'b1;
            out_user_nxt[bfbp_pkg::FLAG_OPENED] = 1'b1;
          end else begin
            res_idx = '0;
            out_user_nxt[bfbp_pkg::FLAG_OVERFLOW] = 1'b1;
          end
          out_data_nxt = {{(bfbp_pkg::OUT_TDATA_W - ID_W - bfbp_pkg::BIDX_W){1'b0}},
                          res_idx_ext[bfbp_pkg::BIDX_W-1:0], id_r};
          state_nxt = bfbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Bin index is reported modulo 64.
  assign res_idx_ext = {{bfbp_pkg::BIDX_W{1'b0}}, res_idx};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfbp_pkg::ST_IDLE;
      open_r    <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      open_r    <= open_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Scan and result payload.
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  bfbp_bin_store #(
    .DEPTH(MAX_BINS),
    .AW   (IW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(scan_r[IW-1:0]),
    .rd_data(rd_data)
  );

  bfbp_fit_cmp #(
    .IW(IW)
  ) u_cmp (
    .clk     (clk),
    .ctrl    (cmp_ctrl),
    .cap     (cap_r),
    .size    (size_r),
    .rem     (rd_data),
    .rem_idx (pend_idx_r),
    .found   (found),
    .best_idx(best_idx),
    .best_rem(best_rem)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the best-fit bin packer with a placement scoreboard.
`timescale 1ns / 1ps

// One predicted placement, with the fields of the result stream.
typedef struct packed {
  logic [bfbp_pkg::ID_W-1:0]   placed_id;
  logic [bfbp_pkg::BIDX_W-1:0] bin_index;
  logic                        opened_new;
  logic                        overflow;
} placement_t;

// Tracks the bins as the block should see them and checks each placement.
class bin_placement_board #(int BINS = 64);
  localparam int ID_W          = bfbp_pkg::ID_W;
  localparam int SIZE_W        = bfbp_pkg::SIZE_W;
  localparam int BIDX_W        = bfbp_pkg::BIDX_W;
  localparam int OUT_TDATA_W   = bfbp_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W   = bfbp_pkg::OUT_TUSER_W;
  localparam int FLAG_OPENED   = bfbp_pkg::FLAG_OPENED;
  localparam int FLAG_OVERFLOW = bfbp_pkg::FLAG_OVERFLOW;

  logic [SIZE_W-1:0] capacity;
  logic [SIZE_W-1:0] bin_space [BINS];
  int unsigned       open_count;
  placement_t        pending_placements [$];
  int unsigned       failures;

  function new();
    capacity   = '0;
    open_count = 0;
    failures   = 0;
    foreach (bin_space[k]) bin_space[k] = '0;
  endfunction

  function void set_capacity(logic [SIZE_W-1:0] value);
    capacity = value;
  endfunction

  // Place one accepted request and queue the placement it must produce.
  function void note_request(bit start, logic [ID_W-1:0] id,
                             logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] need;
    logic [SIZE_W:0]   slack;
    logic [SIZE_W:0]   best_slack;
    int                best;
    bit                found;
    placement_t        p;
    if (start) begin
      open_count = 0;
    end
    need       = (size > capacity) ? capacity : size;
    best_slack = {1'b0, capacity} + 1'b1;
    best       = 0;
    found      = 1'b0;
    // A bin qualifies only if its slack stays below capacity plus one.
    for (int k = 0; k < open_count; k++) begin
      if (bin_space[k] >= need) begin
        slack = {1'b0, bin_space[k]} - {1'b0, need};
        if (slack < best_slack) begin
          best_slack = slack;
          best       = k;
          found      = 1'b1;
        end
      end
    end
    p.placed_id = id;
    if (found) begin
      bin_space[best] = bin_space[best] - need;
      p.bin_index     = BIDX_W'(best);
      p.opened_new    = 1'b0;
      p.overflow      = 1'b0;
    end else if (open_count < BINS) begin
      bin_space[open_count] = capacity - need;
      p.bin_index           = BIDX_W'(open_count);
      p.opened_new          = 1'b1;
      p.overflow            = 1'b0;
      open_count++;
    end else begin
      // Every bin is in use: nothing changes.
      p.bin_index  = '0;
      p.opened_new = 1'b0;
      p.overflow   = 1'b1;
    end
    pending_placements = {pending_placements, p};
  endfunction

  // Compare one accepted result with the oldest predicted placement.
  function void check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] flags);
    placement_t want;
    if (pending_placements.size() == 0) begin
      $error("result with no request outstanding: tdata=%h tuser=%b", data, flags);
      failures++;
      return;
    end
    want = pending_placements.pop_front();
    if (data[ID_W-1:0] !== want.placed_id) begin
      $error("placed_id: expected %0d, actual %0d", want.placed_id, data[ID_W-1:0]);
      failures++;
    end
    if (data[ID_W +: BIDX_W] !== want.bin_index) begin
      $error("bin_index: expected %0d, actual %0d", want.bin_index, data[ID_W +: BIDX_W]);
      failures++;
    end
    if (flags[FLAG_OPENED] !== want.opened_new) begin
      $error("opened_new: expected %0b, actual %0b", want.opened_new, flags[FLAG_OPENED]);
      failures++;
    end
    if (flags[FLAG_OVERFLOW] !== want.overflow) begin
      $error("overflow: expected %0b, actual %0b", want.overflow, flags[FLAG_OVERFLOW]);
      failures++;
    end
  endfunction

  function int unsigned pending();
    return pending_placements.size();
  endfunction
endclass

module testbench;

  localparam int MAX_BINS       = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_SEG  = 150;
  localparam int ID_W           = bfbp_pkg::ID_W;
  localparam int SIZE_W         = bfbp_pkg::SIZE_W;
  localparam int IN_TDATA_W     = bfbp_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W    = bfbp_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W    = bfbp_pkg::OUT_TUSER_W;
  localparam logic [SIZE_W-1:0] FULL_SIZE = {SIZE_W{1'b1}};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [SIZE_W-1:0]      cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  bin_placement_board #(MAX_BINS) board;

  best_fit_bin_packer_top #(
    .MAX_BINS(MAX_BINS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Free-running clock.
  always #10 clk = ~clk;

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check results as they are accepted and watch for a stalled block.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser);
    end
    if ((out_tvalid && out_tready) || (in_tvalid && in_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** best_fit_bin_packer_top: FAILED **");
      $finish;
    end
  end

  // Offer one request, with random gaps ahead of it, and note it once taken.
  task automatic send_request(bit start, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, size, id};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(start, id, size);
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every placement has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Write the bin capacity while the block is idle.
  task automatic write_capacity(logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_capacity(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sizes mostly sit near the capacity so that bins fill up and overflow.
  function automatic logic [SIZE_W-1:0] pick_size(logic [SIZE_W-1:0] cap);
    int unsigned c;
    int unsigned sel;
    c   = cap;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return (c == 0) ? '0 : SIZE_W'($urandom_range(c, c / 2 + 1));
    end else if (sel < 70) begin
      return SIZE_W'($urandom_range(0, c / 4));
    end else if (sel < 82) begin
      return SIZE_W'($urandom_range(0, c));
    end else if (sel < 87) begin
      return '0;
    end else if (sel < 92) begin
      return cap;
    end else begin
      return SIZE_W'($urandom());
    end
  endfunction

  // Capacity of each random segment, the extremes among them.
  function automatic logic [SIZE_W-1:0] capacity_for(int seg);
    case (seg)
      0:       return SIZE_W'(1000);
      1:       return FULL_SIZE;
      2:       return '0;
      3:       return SIZE_W'(1);
      4:       return SIZE_W'($urandom_range(2, 5000));
      5:       return SIZE_W'($urandom());
      6:       return SIZE_W'(64);
      7:       return FULL_SIZE;
      default: return SIZE_W'($urandom_range(100, 100000));
    endcase
  endfunction

  initial begin
    logic [SIZE_W-1:0] cap;
    board     = new();
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 74;

    // Directed: clamping, exact fits, zero sizes, ties and id extremes.
    write_capacity(SIZE_W'(1000));
    send_request(1'b1, '0, SIZE_W'(300));
    send_request(1'b0, {ID_W{1'b1}}, SIZE_W'(700));
    send_request(1'b0, ID_W'(3), '0);
    send_request(1'b0, ID_W'(4), SIZE_W'(2000));
    send_request(1'b0, ID_W'(5), FULL_SIZE);
    send_request(1'b0, ID_W'(6), SIZE_W'(600));
    send_request(1'b0, ID_W'(7), SIZE_W'(600));
    send_request(1'b0, ID_W'(8), SIZE_W'(100));

    // Lowered capacity: older bins keep their space, the slack test still holds.
    write_capacity(SIZE_W'(200));
    send_request(1'b0, ID_W'(9), SIZE_W'(150));
    send_request(1'b0, ID_W'(10), '0);
    send_request(1'b0, ID_W'(11), SIZE_W'(250));
    send_request(1'b0, ID_W'(12), SIZE_W'(200));

    // Full capacity, a start with a zero-size item, then a zero capacity.
    write_capacity(FULL_SIZE);
    send_request(1'b1, ID_W'($urandom()), SIZE_W'($urandom()));
    send_request(1'b0, ID_W'(14), FULL_SIZE);
    send_request(1'b1, ID_W'(15), '0);
    send_request(1'b0, ID_W'(16), SIZE_W'(1));
    write_capacity('0);
    send_request(1'b0, ID_W'(17), SIZE_W'(5));
    send_request(1'b1, ID_W'(18), FULL_SIZE);
    send_request(1'b0, ID_W'(19), '0);

    // Random: three pacing phases, each with several capacity settings.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 32 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        cap = capacity_for(phase * 3 + seg);
        write_capacity(cap);
        repeat (ITEMS_PER_SEG) begin
          send_request($urandom_range(0, 149) == 0, ID_W'($urandom()), pick_size(cap));
        end
      end
    end

    wait_drained();
    repeat (MAX_BINS + 8) @(negedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** best_fit_bin_packer_top: PASSED **");
    end else begin
      $display("** best_fit_bin_packer_top: FAILED **");
    end
    $finish;
  end

endmodule
